// File: rtl/aabf_pkg.sv
// Shared types and constants for the active-active bloom filter unit.
// Used by active_active_bloom_filter_unit and its testbench; depends on nothing.
package aabf_pkg;

  // control sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TEST,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HASH_COUNT  = 2'd0,
    CFG_SIZE_LOG2   = 2'd1,
    CFG_ENTRY_LIMIT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  // register reset values
  localparam logic [4:0]  HASH_COUNT_RST  = 5'd10;
  localparam logic [4:0]  SIZE_LOG2_RST   = 5'd16;
  localparam logic [15:0] ENTRY_LIMIT_RST = 16'd4558;

endpackage

// File: rtl/active_active_bloom_filter_unit.sv
// Active-active buffered bloom filter: two bit arrays held in two aabf_ram instances.
// Depends on aabf_pkg and aabf_ram.
//
// One word in gives one word out: m_axis_tdata[0] tells whether the key digest was
// present in either array before this word. Items are handled one at a time, and the
// cost is set by the single-port arrays, one word access per array per cycle. With k
// hash indices, a word is tested with k reads, and when the key is inserted into the
// first array it also takes k reads and k writes back. A result word that waits on
// m_axis_tready holds the next word in S_DONE. When the insert count passes
// entry_limit, the second array is wiped one word per cycle over its whole depth, the
// arrays swap and the key is inserted again. After reset both arrays are wiped the
// same way before the first input word is taken; configuration writes are taken at all
// times.
module active_active_bloom_filter_unit #(
  parameter int MAX_SIZE_LOG2 = 16,
  parameter int MAX_HASHES    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] key_digest
  input  logic        s_axis_tuser,   // [0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] seen, [7:1] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int WORD_LOG2 = (MAX_SIZE_LOG2 >= 8) ? 5 : 2;
  localparam int WORD_BITS = 1 << WORD_LOG2;
  localparam int AW        = MAX_SIZE_LOG2 - WORD_LOG2;
  localparam int DEPTH     = 1 << AW;
  localparam int KW        = $clog2(MAX_HASHES + 1);
  localparam logic [5:0] HASH_MAX = 6'(MAX_HASHES);
  localparam logic [5:0] SIZE_MAX = 6'(MAX_SIZE_LOG2);

  aabf_pkg::state_t state, state_next;

  // configuration registers
  logic [4:0]  hash_count;
  logic [4:0]  size_log2;
  logic [15:0] entry_limit;

  // filter state
  logic        first_is_b;
  logic [16:0] insert_count;

  // item registers
  logic        func;
  logic [31:0] h0;
  logic [31:0] h1;
  logic [31:0] acc;
  logic [KW-1:0] cnt;
  logic        pres_first;
  logic        pres_second;
  logic        chk_valid;
  logic [WORD_LOG2-1:0] chk_bit;
  logic        swapped;
  logic        clr_both;
  logic [AW-1:0] clr_addr;

  // memory ports
  logic          we_a, we_b;
  logic [AW-1:0] mem_addr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata_a, rdata_b;
  logic [WORD_BITS-1:0] rdata_first;

  // derived values
  logic [5:0]  k_wide;
  logic [KW-1:0] k_eff;
  logic [5:0]  s_eff;
  logic [MAX_SIZE_LOG2-1:0] mask;
  logic [MAX_SIZE_LOG2-1:0] idx;
  logic [KW-1:0] cnt_inc;
  logic [16:0] count_inc;
  logic        last_ins;
  logic        bit_first, bit_second;
  logic        pf_now, ps_now;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == aabf_pkg::S_IDLE);

  // effective hash count, clamped to 2..MAX_HASHES
  always_comb begin
    if (hash_count < 5'd2) begin
      k_wide = 6'd2;
    end else if ({1'b0, hash_count} > HASH_MAX) begin
      k_wide = HASH_MAX;
    end else begin
      k_wide = {1'b0, hash_count};
    end
    k_eff = k_wide[KW-1:0];
  end

  // effective index mask, size clamped to 1..MAX_SIZE_LOG2
  always_comb begin
    if (size_log2 == 5'd0) begin
      s_eff = 6'd1;
    end else if ({1'b0, size_log2} > SIZE_MAX) begin
      s_eff = SIZE_MAX;
    end else begin
      s_eff = {1'b0, size_log2};
    end
    for (int j = 0; j < MAX_SIZE_LOG2; j++) begin
      mask[j] = (6'(j) < s_eff);
    end
  end

  assign idx         = acc[MAX_SIZE_LOG2-1:0] & mask;
  assign cnt_inc     = cnt + 1'b1;
  assign count_inc   = insert_count + 17'd1;
  assign last_ins    = (cnt_inc == k_eff);
  assign rdata_first = first_is_b ? rdata_b : rdata_a;

  // bit under test from the word read last cycle
  assign bit_first  = first_is_b ? rdata_b[chk_bit] : rdata_a[chk_bit];
  assign bit_second = first_is_b ? rdata_a[chk_bit] : rdata_b[chk_bit];
  assign pf_now     = pres_first & (~chk_valid | bit_first);
  assign ps_now     = pres_second & (~chk_valid | bit_second);

  // next state and memory controls
  always_comb begin
    state_next = state;
    we_a       = 1'b0;
    we_b       = 1'b0;
    mem_addr   = idx[MAX_SIZE_LOG2-1:WORD_LOG2];
    wdata      = rdata_first | (WORD_BITS'(1) << chk_bit);
    case (state)
      aabf_pkg::S_CLEAR: begin
        mem_addr = clr_addr;
        wdata    = '0;
        we_a     = clr_both | first_is_b;
        we_b     = clr_both | ~first_is_b;
        if (clr_addr == '1) begin
          state_next = clr_both ? aabf_pkg::S_IDLE : aabf_pkg::S_INS_RD;
        end
      end
      aabf_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = aabf_pkg::S_TEST;
        end
      end
      aabf_pkg::S_TEST: begin
        if (cnt == k_eff && !chk_valid) begin
          if (pres_first) begin
            state_next = aabf_pkg::S_DONE;
          end else if (func || pres_second) begin
            state_next = aabf_pkg::S_INS_RD;
          end else begin
            state_next = aabf_pkg::S_DONE;
          end
        end
      end
      aabf_pkg::S_INS_RD: begin
        state_next = aabf_pkg::S_INS_WR;
      end
      aabf_pkg::S_INS_WR: begin
        we_a     = ~first_is_b;
        we_b     = first_is_b;
        if (!last_ins) begin
          state_next = aabf_pkg::S_INS_RD;
        end else if (swapped) begin
          state_next = aabf_pkg::S_DONE;
        end else if (count_inc > {1'b0, entry_limit}) begin
          state_next = aabf_pkg::S_CLEAR;
        end else begin
          state_next = aabf_pkg::S_DONE;
        end
      end
      aabf_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = aabf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = aabf_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aabf_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count  <= aabf_pkg::HASH_COUNT_RST;
      size_log2   <= aabf_pkg::SIZE_LOG2_RST;
      entry_limit <= aabf_pkg::ENTRY_LIMIT_RST;
    end else if (cfg_valid) begin
      case (aabf_pkg::cfg_index_t'(cfg_index))
        aabf_pkg::CFG_HASH_COUNT:  hash_count  <= cfg_data[4:0];
        aabf_pkg::CFG_SIZE_LOG2:   size_log2   <= cfg_data[4:0];
        aabf_pkg::CFG_ENTRY_LIMIT: entry_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: clear sweep, array roles, insert count, result word
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_both      <= 1'b1;
      clr_addr      <= '0;
      first_is_b    <= 1'b0;
      insert_count  <= '0;
      swapped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result word handshake
      if (state == aabf_pkg::S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        aabf_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            clr_both <= 1'b0;
            if (!clr_both) begin
              first_is_b   <= ~first_is_b;
              insert_count <= 17'd1;
              swapped      <= 1'b1;
            end
          end
        end
        aabf_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            swapped <= 1'b0;
          end
        end
        aabf_pkg::S_INS_WR: begin
          if (last_ins && !swapped && count_inc <= {1'b0, entry_limit}) begin
            insert_count <= count_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // item datapath: index walk and presence checks
  always_ff @(posedge clk) begin
    case (state)
      aabf_pkg::S_CLEAR: begin
        acc <= h0;
        cnt <= '0;
      end
      aabf_pkg::S_IDLE: begin
        func        <= s_axis_tuser;
        h0          <= s_axis_tdata[31:0];
        h1          <= s_axis_tdata[63:32];
        acc         <= s_axis_tdata[31:0];
        cnt         <= '0;
        pres_first  <= 1'b1;
        pres_second <= 1'b1;
        chk_valid   <= 1'b0;
      end
      aabf_pkg::S_TEST: begin
        pres_first  <= pf_now;
        pres_second <= ps_now;
        if (cnt != k_eff) begin
          chk_bit   <= idx[WORD_LOG2-1:0];
          chk_valid <= 1'b1;
          acc       <= acc + h1;
          cnt       <= cnt_inc;
        end else begin
          chk_valid <= 1'b0;
          acc       <= h0;
          if (!chk_valid) begin
            cnt <= '0;
          end
        end
      end
      aabf_pkg::S_INS_RD: begin
        chk_bit <= idx[WORD_LOG2-1:0];
      end
      aabf_pkg::S_INS_WR: begin
        acc <= last_ins ? h0 : acc + h1;
        cnt <= last_ins ? '0 : cnt_inc;
      end
      aabf_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {7'd0, pres_first | pres_second};
        end
      end
      default: ;
    endcase
  end

  // array a
  aabf_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .addr (mem_addr),
    .wdata(wdata),
    .rdata(rdata_a)
  );

  // array b
  aabf_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .addr (mem_addr),
    .wdata(wdata),
    .rdata(rdata_b)
  );

endmodule

// File: rtl/aabf_ram.sv
// Generic single-port RAM with registered read (read-first).
// No dependencies.
module aabf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: tb/active_active_bloom_filter_unit_tb.sv
// Self-checking testbench for active_active_bloom_filter_unit: random and directed key words
// checked against a bit-level model of both bloom arrays. Depends on aabf_pkg and the unit.
`timescale 1ns / 1ps

module active_active_bloom_filter_unit_tb;

  localparam int   ARRAY_LOG2 = 16;
  localparam int   HASH_LIMIT = 16;
  localparam logic FUNC_TEST  = 1'b0;
  localparam logic FUNC_SET   = 1'b1;

  // tracks both bit arrays and the expected seen flags
  class bloom_scoreboard;
    bit [65535:0] bank [2];
    bit           first_sel;
    bit [16:0]    insert_count;
    bit [4:0]     hash_count;
    bit [4:0]     size_log2;
    bit [15:0]    entry_limit;
    bit           expected_seen [$];
    int           errors;

    function new();
      bank[0]      = '0;
      bank[1]      = '0;
      first_sel    = 1'b0;
      insert_count = '0;
      hash_count   = aabf_pkg::HASH_COUNT_RST;
      size_log2    = aabf_pkg::SIZE_LOG2_RST;
      entry_limit  = aabf_pkg::ENTRY_LIMIT_RST;
      errors       = 0;
    endfunction

    function int unsigned hash_total();
      int unsigned k;
      k = hash_count;
      if (k < 2) k = 2;
      if (k > HASH_LIMIT) k = HASH_LIMIT;
      return k;
    endfunction

    function bit [31:0] index_mask();
      int unsigned s;
      s = size_log2;
      if (s < 1) s = 1;
      if (s > ARRAY_LOG2) s = ARRAY_LOG2;
      return (32'd1 << s) - 32'd1;
    endfunction

    // all k bits of the key set in one array
    function bit key_in(bit sel, bit [31:0] h0, bit [31:0] h1);
      bit [31:0]   idx;
      int unsigned k;
      k = hash_total();
      for (int unsigned i = 0; i < k; i++) begin
        idx = (h0 + i * h1) & index_mask();
        if (!bank[sel][idx[15:0]]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void key_set(bit sel, bit [31:0] h0, bit [31:0] h1);
      bit [31:0]   idx;
      int unsigned k;
      k = hash_total();
      for (int unsigned i = 0; i < k; i++) begin
        idx = (h0 + i * h1) & index_mask();
        bank[sel][idx[15:0]] = 1'b1;
      end
    endfunction

    // insert into the first array, swap and wipe once the limit is passed
    function void count_insert(bit [31:0] h0, bit [31:0] h1);
      key_set(first_sel, h0, h1);
      insert_count = insert_count + 17'd1;
      if (insert_count > entry_limit) begin
        bank[!first_sel] = '0;
        first_sel        = !first_sel;
        key_set(first_sel, h0, h1);
        insert_count     = 17'd1;
      end
    endfunction

    function void note_word(logic func, logic [63:0] digest);
      bit [31:0] h0;
      bit [31:0] h1;
      bit        seen;
      h0 = digest[31:0];
      h1 = digest[63:32];
      if (key_in(first_sel, h0, h1)) begin
        seen = 1'b1;
      end else begin
        seen = key_in(!first_sel, h0, h1);
        if (func || seen) count_insert(h0, h1);
      end
      expected_seen.push_back(seen);
    endfunction

    function void apply_config(aabf_pkg::cfg_index_t idx, logic [15:0] val);
      case (idx)
        aabf_pkg::CFG_HASH_COUNT:  hash_count  = val[4:0];
        aabf_pkg::CFG_SIZE_LOG2:   size_log2   = val[4:0];
        aabf_pkg::CFG_ENTRY_LIMIT: entry_limit = val;
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [7:0] word);
      bit exp_seen;
      if (expected_seen.size() == 0) begin
        report($sformatf("result word %h with nothing expected", word));
      end else begin
        exp_seen = expected_seen.pop_front();
        if (word[0] !== exp_seen)
          report($sformatf("seen %b, expected %b", word[0], exp_seen));
        if (word[7:1] !== 7'd0)
          report($sformatf("padding bits %b not zero", word[7:1]));
      end
    endtask

    task finish_check();
      if (expected_seen.size() != 0)
        report($sformatf("%0d results never arrived", expected_seen.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] key_digest
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] seen, [7:1] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bloom_scoreboard board;
  logic [63:0]     digest_pool [$];
  logic [15:0]     stall_pat = 16'hffff;
  int              pat_age = 0;

  active_active_bloom_filter_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted words, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
    if (pat_age == 150) begin
      pat_age <= 0;
      case ($urandom_range(0, 4))
        0: stall_pat <= 16'hffff;
        1: stall_pat <= 16'h00ff;
        2: stall_pat <= 16'h0001;
        default: stall_pat <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      pat_age   <= pat_age + 1;
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    m_axis_tready <= stall_pat[0];
  end

  // present one key word and hold it until taken
  task automatic send_word(input logic func, input logic [63:0] digest);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= digest;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_word(func, digest);
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(input aabf_pkg::cfg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.apply_config(idx, val);
  endtask

  task automatic configure(input logic [4:0] hc, input logic [4:0] sz, input logic [15:0] lim);
    logic [10:0] hi_a;
    logic [10:0] hi_b;
    hi_a = 11'($urandom_range(0, 2047));
    hi_b = 11'($urandom_range(0, 2047));
    write_reg(aabf_pkg::CFG_HASH_COUNT, {hi_a, hc});
    write_reg(aabf_pkg::CFG_SIZE_LOG2, {hi_b, sz});
    write_reg(aabf_pkg::CFG_ENTRY_LIMIT, lim);
    write_reg(aabf_pkg::CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // wait until every result is back and the unit has settled
  task automatic wait_idle();
    while (board.expected_seen.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // reused keys in four of ten picks so lookups hit, the rest fresh or degenerate
  function automatic logic [63:0] pick_digest();
    logic [63:0] d;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 4 && digest_pool.size() > 0) begin
      d = digest_pool[$urandom_range(0, digest_pool.size() - 1)];
    end else begin
      d = {$urandom, $urandom};
      if (r == 4) d[63:32] = '0;
      if (r == 5) d[31:0] = '0;
      if (r == 6 && $urandom_range(0, 3) == 0) d = '1;
      digest_pool.push_back(d);
      if (digest_pool.size() > 32) void'(digest_pool.pop_front());
    end
    return d;
  endfunction

  // random words in bursts with random gaps, sometimes no gaps at all
  task automatic run_items(input int n);
    int   burst;
    int   gap;
    bit   calm;
    logic func;
    calm  = ($urandom_range(0, 3) == 0);
    burst = 0;
    for (int j = 0; j < n; j++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= {$urandom, $urandom};
          s_axis_tuser  <= 1'($urandom);
          repeat (gap) @(posedge clk);
        end
      end
      func = 1'($urandom_range(0, 1));
      send_word(func, pick_digest());
      burst--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] hc, input logic [4:0] sz,
                           input logic [15:0] lim, input int n);
    wait_idle();
    configure(hc, sz, lim);
    digest_pool.delete();
    run_items(n);
  endtask

  // watchdog
  initial begin
    #250_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero and all-ones keys, repeats, zero and unit step
    send_word(FUNC_SET,  64'h0);
    send_word(FUNC_TEST, 64'h0);
    send_word(FUNC_TEST, '1);
    send_word(FUNC_SET,  '1);
    send_word(FUNC_TEST, '1);
    send_word(FUNC_TEST, 64'h0123_4567_89ab_cdef);
    send_word(FUNC_SET,  64'h0123_4567_89ab_cdef);
    send_word(FUNC_SET,  64'h0123_4567_89ab_cdef);
    send_word(FUNC_TEST, 64'haaaa_aaaa_5555_5555);
    send_word(FUNC_SET,  64'h5555_5555_aaaa_aaaa);
    send_word(FUNC_TEST, 64'h5555_5555_aaaa_aaaa);
    send_word(FUNC_SET,  64'h0000_0001_0000_0000);
    s_axis_tvalid <= 1'b0;

    // clamped hash count and size, limit of one: key found only in the second array
    wait_idle();
    configure(5'd0, 5'd0, 16'd1);
    send_word(FUNC_SET,  64'h0);
    send_word(FUNC_SET,  64'h1);
    send_word(FUNC_TEST, 64'h0);
    send_word(FUNC_TEST, 64'h1);
    send_word(FUNC_TEST, 64'h2);
    send_word(FUNC_SET,  64'hffff_ffff_0000_0003);
    send_word(FUNC_TEST, 64'h0000_0001_0000_0000);
    send_word(FUNC_SET,  64'h5);
    s_axis_tvalid <= 1'b0;

    // random phases across settings, extremes included
    run_phase(5'd10, 5'd16, 16'd4558, 200);
    run_phase(5'd2,  5'd3,  16'd5,    150);
    run_phase(5'd16, 5'd8,  16'd20,   150);
    run_phase(5'd0,  5'd0,  16'd0,    30);
    run_phase(5'd31, 5'd31, 16'd65535, 200);
    run_phase(5'd1,  5'd1,  16'd1,    40);
    run_phase(5'd5,  5'd12, 16'd50,   150);
    run_phase(5'd17, 5'd4,  16'd65535, 100);
    repeat (4) begin
      run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 20)),
                16'($urandom_range(3, 300)), 120);
    end

    while (board.expected_seen.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    board.finish_check();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/aabf_pkg.sv
rtl/aabf_ram.sv
rtl/active_active_bloom_filter_unit.sv
tb/active_active_bloom_filter_unit_tb.sv
